FILE: design/bmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmt_pkg
// Shared types and constants for the bracket match tracker: the transfer
// structs, the bracket record, the command, kind and status codes, and the
// stack cell operations.
// ----------------------------------------------------------------------------
package bmt_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] CMD_OPEN  = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  localparam logic [1:0] KIND_STATUS   = 2'd0;
  localparam logic [1:0] KIND_MISMATCH = 2'd1;
  localparam logic [1:0] KIND_HILITE   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_HILITE    = 2'd1;
  localparam logic [1:0] ST_UNMATCHED = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic [15:0] line;
    logic [15:0] col;
    logic [7:0]  ch;
  } brec_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  bracket_char;
    logic [15:0] text_line;
    logic [15:0] text_col;
    logic [23:0] char_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [15:0] rec_line;
    logic [15:0] rec_col;
    logic [7:0]  rec_char;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP
  } stk_op_t;

  typedef struct packed {
    stk_op_t op;
    brec_t   push_rec;
  } stk_ctrl_t;

endpackage

FILE: design/bmt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmt_cell
// One stack slot. Takes the record from above on a push, from below on a
// pop, and holds otherwise.
// ----------------------------------------------------------------------------
module bmt_cell (
  input  logic           clk,
  input  bmt_pkg::stk_op_t op,
  input  bmt_pkg::brec_t from_above,
  input  bmt_pkg::brec_t from_below,
  output bmt_pkg::brec_t q
);
  import bmt_pkg::*;

  brec_t rec_r;
  brec_t rec_nxt;

  always_comb begin
    case (op)
      STK_PUSH: rec_nxt = from_above;
      STK_POP:  rec_nxt = from_below;
      default:  rec_nxt = rec_r;
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign q = rec_r;

endmodule

FILE: design/bmt_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmt_stack
// Shift stack built as a row of cells. Cell 0 is the top; a push moves every
// record one cell down, a pop one cell up.
// ----------------------------------------------------------------------------
module bmt_stack (
  input  logic              clk,
  input  bmt_pkg::stk_ctrl_t ctrl,
  output bmt_pkg::brec_t    top_rec
);
  import bmt_pkg::*;

  brec_t cell_q [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    brec_t above;
    brec_t below;

    if (i == 0) begin : g_top
      assign above = ctrl.push_rec;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end

    // bottom cell refills from itself; that slot lies beyond the count
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = cell_q[i];
    end else begin : g_up
      assign below = cell_q[i+1];
    end

    bmt_cell u_cell (
      .clk        (clk),
      .op         (ctrl.op),
      .from_above (above),
      .from_below (below),
      .q          (cell_q[i])
    );
  end

  assign top_rec = cell_q[0];

endmodule

FILE: design/bracket_match_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_match_tracker_core
// Bracket tracker: keeps open brackets on a shift stack of cells, reports
// mismatched records on close and flush, and tracks the cursor highlight.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   in_     | input     | in_valid/in_stall  | in_data  (in_item_t)
//   out_    | output    | out_valid/out_stall| out_data (out_item_t)
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_data (cursor offset, 24b)
//
// An open's single result is loaded on its accept edge. A close or flush
// enters a busy state, then loads its results in turn; the stack pops one
// cell per cycle while out_ is free. Reset (rst_n low, synchronous) clears
// the count, highlight, cursor and output valid; stack cells and payloads
// are not reset. in_ stalls while a close or flush runs or out_ is blocked;
// a stall on out_ holds the output register and freezes the sequencer.
// ----------------------------------------------------------------------------
module bracket_match_tracker_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bmt_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bmt_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [23:0]         cfg_data
);
  import bmt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLOSE,
    S_FLUSH
  } state_t;

  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  brec_t           hl_r, hl_nxt;
  logic [23:0]     cursor_r;
  logic [7:0]      match_ch_r, match_ch_nxt;
  logic            at_cursor_r, at_cursor_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;

  stk_ctrl_t       stk_ctrl;
  brec_t           top_rec;
  brec_t           in_rec;

  logic            out_free;
  logic            in_xfer;
  logic            cnt_full;
  logic            cnt_empty;
  logic            in_at_cursor;

  // Output register frees up when empty or when its transfer completes.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign cnt_full     = (count_r == CNT_W'(STACK_DEPTH));
  assign cnt_empty    = (count_r == '0);
  assign in_at_cursor = (in_data.char_offset == cursor_r);

  assign in_rec = '{line: in_data.text_line, col: in_data.text_col,
                    ch: in_data.bracket_char};

  bmt_stack u_stack (
    .clk     (clk),
    .ctrl    (stk_ctrl),
    .top_rec (top_rec)
  );

  function automatic out_item_t mk_out(logic [1:0] kind, logic [1:0] status,
                                       brec_t r, logic last);
    out_item_t o;
    o.kind     = kind;
    o.status   = status;
    o.rec_line = r.line;
    o.rec_col  = r.col;
    o.rec_char = r.ch;
    o.last     = last;
    return o;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    hl_nxt        = hl_r;
    match_ch_nxt  = match_ch_r;
    at_cursor_nxt = at_cursor_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    stk_ctrl.op       = STK_HOLD;
    stk_ctrl.push_rec = in_rec;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_data.cmd)
            CMD_OPEN: begin
              out_valid_nxt = 1'b1;
              if (cnt_full) begin
                // drop the push and flag it
                out_nxt = mk_out(KIND_STATUS, ST_OVERFLOW, '0, 1'b1);
              end else begin
                stk_ctrl.op = STK_PUSH;
                count_nxt   = count_r + 1'b1;
                if (in_at_cursor) begin
                  hl_nxt  = in_rec;
                  out_nxt = mk_out(KIND_STATUS, ST_HILITE, '0, 1'b1);
                end else begin
                  out_nxt = mk_out(KIND_STATUS, ST_OK, '0, 1'b1);
                end
              end
            end
            CMD_CLOSE: begin
              match_ch_nxt  = in_data.bracket_char;
              at_cursor_nxt = in_at_cursor;
              state_nxt     = S_CLOSE;
            end
            CMD_FLUSH: begin
              state_nxt = S_FLUSH;
            end
            default: ;  // unused command: no result
          endcase
        end
      end

      S_CLOSE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (cnt_empty) begin
            out_nxt   = mk_out(KIND_STATUS, ST_UNMATCHED, '0, 1'b1);
            state_nxt = S_IDLE;
          end else begin
            stk_ctrl.op = STK_POP;
            count_nxt   = count_r - 1'b1;
            if (top_rec.ch != match_ch_r) begin
              out_nxt = mk_out(KIND_MISMATCH, ST_OK, top_rec, 1'b0);
            end else begin
              state_nxt = S_IDLE;
              if (at_cursor_r) begin
                hl_nxt  = top_rec;
                out_nxt = mk_out(KIND_STATUS, ST_HILITE, '0, 1'b1);
              end else if (top_rec == hl_r) begin
                hl_nxt.ch = '0;
                out_nxt   = mk_out(KIND_STATUS, ST_HILITE, '0, 1'b1);
              end else begin
                out_nxt = mk_out(KIND_STATUS, ST_OK, '0, 1'b1);
              end
            end
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (!cnt_empty) begin
            stk_ctrl.op = STK_POP;
            count_nxt   = count_r - 1'b1;
            // last record ends the flush when there is no highlight to report
            if ((count_r == CNT_W'(1)) && (hl_r.ch == '0)) begin
              out_nxt   = mk_out(KIND_MISMATCH, ST_OK, top_rec, 1'b1);
              hl_nxt    = '0;
              state_nxt = S_IDLE;
            end else begin
              out_nxt = mk_out(KIND_MISMATCH, ST_OK, top_rec, 1'b0);
            end
          end else begin
            if (hl_r.ch != '0) begin
              out_nxt = mk_out(KIND_HILITE, ST_OK, hl_r, 1'b1);
            end else begin
              out_nxt = mk_out(KIND_STATUS, ST_OK, '0, 1'b1);
            end
            hl_nxt    = '0;
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    // Payload registers: no reset needed.
    match_ch_r  <= match_ch_nxt;
    at_cursor_r <= at_cursor_nxt;
    out_r       <= out_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      hl_r        <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      hl_r        <= hl_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cursor_r <= cfg_data;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_overflow_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_data.cmd == CMD_OPEN) && cnt_full) |=> $stable(count_r))
    else $error("overflowing push changed the stack count");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_free && out_valid_nxt && out_nxt.last && (state_r != S_IDLE))
      |=> (state_r == S_IDLE))
    else $error("final result loaded but sequencer still busy");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FLUSH) && out_free && cnt_empty) |=> (hl_r == '0))
    else $error("flush left a highlight behind");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bracket_match_tracker_core. A behavioral tracker
// follows every accepted input transfer. It keeps its own bracket stack,
// highlight and cursor, and queues the report transfers that each input
// should produce. Every output transfer is compared field by field with the
// oldest queued report. Stimulus starts with a directed set (empty flush,
// matched pairs, mismatched and unmatched closes, field extremes, the unused
// command), then fills the stack past full, then runs random bracket streams
// under three idle profiles and several cursor settings.
// ----------------------------------------------------------------------------
module tb_top;
  import bmt_pkg::*;

  // cmd 3 has no name in the package; the block ignores it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // idle cycles before a cursor write; covers the longest flush in flight
  localparam int DRAIN_CYCLES = 40;
  // cycles with no transfer on any channel before the run is called hung
  localparam int QUIET_LIMIT  = 4000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [23:0] cfg_data;

  // idle rates in percent, changed between phases by the main sequence
  int in_idle_pct;
  int out_idle_pct;

  int err_count;
  int quiet_cycles;

  // tracker state: mirrors what the block should hold
  brec_t       open_brackets [STACK_DEPTH];
  int          open_count;
  brec_t       hilite_rec;
  logic [23:0] cursor_shadow;

  // report transfers still owed by the block, oldest first
  out_item_t   expected_reports [$];

  bracket_match_tracker_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Clock: 20 ns period
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Tracker
  // --------------------------------------------------------------------------
  function automatic out_item_t make_report(input logic [1:0] kind,
                                            input logic [1:0] status,
                                            input brec_t rec);
    out_item_t r;
    r.kind     = kind;
    r.status   = status;
    r.rec_line = rec.line;
    r.rec_col  = rec.col;
    r.rec_char = rec.ch;
    r.last     = 1'b0;
    return r;
  endfunction

  // Advance the tracker by one accepted input and queue the reports it owes.
  function automatic void track_brackets(input in_item_t it);
    out_item_t  batch [$];
    out_item_t  r;
    brec_t      rec;
    brec_t      match;
    logic [1:0] st;
    rec.line = it.text_line;
    rec.col  = it.text_col;
    rec.ch   = it.bracket_char;
    st       = ST_OK;
    case (it.cmd)
      CMD_OPEN: begin
        if (open_count >= STACK_DEPTH) begin
          // full stack: drop the push, leave the highlight alone
          st = ST_OVERFLOW;
        end else begin
          open_brackets[open_count] = rec;
          open_count++;
          if (it.char_offset == cursor_shadow) begin
            hilite_rec = rec;
            st = ST_HILITE;
          end
        end
        batch.push_back(make_report(KIND_STATUS, st, '0));
      end
      CMD_CLOSE: begin
        // pop every top record that is not the named opener
        while (open_count > 0 && open_brackets[open_count - 1].ch != rec.ch) begin
          open_count--;
          batch.push_back(make_report(KIND_MISMATCH, ST_OK, open_brackets[open_count]));
        end
        if (open_count == 0) begin
          st = ST_UNMATCHED;
        end else begin
          open_count--;
          match = open_brackets[open_count];
          if (it.char_offset == cursor_shadow) begin
            hilite_rec = match;
            st = ST_HILITE;
          end else if (match == hilite_rec) begin
            // clear only the character; line and column stay behind
            hilite_rec.ch = '0;
            st = ST_HILITE;
          end
        end
        batch.push_back(make_report(KIND_STATUS, st, '0));
      end
      CMD_FLUSH: begin
        while (open_count > 0) begin
          open_count--;
          batch.push_back(make_report(KIND_MISMATCH, ST_OK, open_brackets[open_count]));
        end
        if (hilite_rec.ch != '0)
          batch.push_back(make_report(KIND_HILITE, ST_OK, hilite_rec));
        hilite_rec = '0;
        if (batch.size() == 0)
          batch.push_back(make_report(KIND_STATUS, ST_OK, '0));
      end
      default: ;
    endcase
    for (int i = 0; i < batch.size(); i++) begin
      r = batch[i];
      r.last = (i == batch.size() - 1);
      expected_reports.push_back(r);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitors: sample at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      track_brackets(in_data);
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready)
      cursor_shadow = cfg_data;
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    err_count++;
    $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
  endtask

  // Compare each output transfer with the oldest owed report.
  always @(posedge clk) begin : check_reports
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        flag_mismatch("unexpected result", 64'(out_data), '0);
      end else begin
        want = expected_reports.pop_front();
        if (out_data.kind !== want.kind)
          flag_mismatch("kind", 64'(out_data.kind), 64'(want.kind));
        if (out_data.status !== want.status)
          flag_mismatch("status", 64'(out_data.status), 64'(want.status));
        if (out_data.rec_line !== want.rec_line)
          flag_mismatch("rec_line", 64'(out_data.rec_line), 64'(want.rec_line));
        if (out_data.rec_col !== want.rec_col)
          flag_mismatch("rec_col", 64'(out_data.rec_col), 64'(want.rec_col));
        if (out_data.rec_char !== want.rec_char)
          flag_mismatch("rec_char", 64'(out_data.rec_char), 64'(want.rec_char));
        if (out_data.last !== want.last)
          flag_mismatch("last", 64'(out_data.last), 64'(want.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run after too many cycles with no transfer anywhere
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall at random, drive at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Sender helpers. All of them are entered and left at a falling edge.
  // --------------------------------------------------------------------------

  // Send one input transfer, idling first at the current sender rate.
  // On return in_valid is still high; the caller drives it in this same step.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold the sender off until every owed report has been seen.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
  endtask

  // Write the cursor register; only called with the block idle.
  task automatic write_cursor(input logic [23:0] value);
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_item(input logic [1:0] cmd, input logic [7:0] ch,
                                         input logic [15:0] line,
                                         input logic [15:0] col,
                                         input logic [23:0] off);
    in_item_t it;
    it.cmd          = cmd;
    it.bracket_char = ch;
    it.text_line    = line;
    it.text_col     = col;
    it.char_offset  = off;
    return it;
  endfunction

  function automatic logic [7:0] pick_opener();
    case ($urandom_range(3))
      0:       return "(";
      1:       return "[";
      2:       return "{";
      default: return "<";
    endcase
  endfunction

  // Random position; the offset lands on the cursor about one time in four.
  function automatic in_item_t random_position(input logic [1:0] cmd,
                                               input logic [7:0] ch);
    logic [23:0] off;
    off = ($urandom_range(3) == 0) ? cursor_shadow : 24'($urandom());
    return make_item(cmd, ch, 16'($urandom()), 16'($urandom()), off);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Flush on an empty block, then flush a stack with a highlight.
  task automatic test_flush();
    send_item(make_item(CMD_FLUSH, 8'h00, 16'd0, 16'd0, 24'd0));
    send_item(make_item(CMD_OPEN, "(", 16'd1, 16'd2, cursor_shadow));
    send_item(make_item(CMD_OPEN, "[", 16'd1, 16'd5, cursor_shadow + 24'd1));
    send_item(make_item(CMD_FLUSH, 8'h00, 16'd9, 16'd9, 24'd0));
    send_item(make_item(CMD_FLUSH, 8'h00, 16'd9, 16'd9, 24'd0));
  endtask

  // Matched pairs: set the highlight on open, clear it when its pair closes.
  task automatic test_matched_pairs();
    send_item(make_item(CMD_OPEN, "(", 16'd3, 16'd0, cursor_shadow));
    send_item(make_item(CMD_OPEN, "[", 16'd3, 16'd4, cursor_shadow + 24'd4));
    send_item(make_item(CMD_CLOSE, "[", 16'd3, 16'd8, cursor_shadow + 24'd8));
    send_item(make_item(CMD_CLOSE, "(", 16'd3, 16'd9, cursor_shadow + 24'd9));
  endtask

  // Close that skips two openers; its match lands on the cursor.
  task automatic test_mismatched_close();
    send_item(make_item(CMD_OPEN, "{", 16'd4, 16'd0, 24'd1));
    send_item(make_item(CMD_OPEN, "<", 16'd4, 16'd1, 24'd2));
    send_item(make_item(CMD_OPEN, "[", 16'd4, 16'd2, 24'd3));
    send_item(make_item(CMD_CLOSE, "{", 16'd4, 16'd3, cursor_shadow));
  endtask

  // Close on an empty stack, and a close that empties the stack.
  task automatic test_unmatched_close();
    send_item(make_item(CMD_CLOSE, "(", 16'd5, 16'd0, 24'd7));
    send_item(make_item(CMD_OPEN, "a", 16'd5, 16'd1, 24'd8));
    send_item(make_item(CMD_CLOSE, "(", 16'd5, 16'd2, 24'd9));
  endtask

  // All-ones and all-zero fields, including a zero bracket character.
  task automatic test_field_extremes();
    send_item(make_item(CMD_OPEN, 8'hFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF));
    send_item(make_item(CMD_OPEN, 8'h00, 16'h0000, 16'h0000, 24'h000000));
    send_item(make_item(CMD_CLOSE, 8'h00, 16'hFFFF, 16'h0000, 24'hFFFFFF));
    send_item(make_item(CMD_CLOSE, 8'hFF, 16'h0000, 16'hFFFF, 24'h000000));
    send_item(make_item(CMD_FLUSH, 8'hFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF));
  endtask

  // The unused command changes nothing and owes no report.
  task automatic test_ignored_command();
    send_item(random_position(CMD_UNUSED, 8'($urandom())));
    send_item(random_position(CMD_UNUSED, "("));
    send_item(make_item(CMD_OPEN, "<", 16'd6, 16'd0, 24'd11));
  endtask

  // Fill the stack, push past full (once at the cursor), then flush it all.
  task automatic test_stack_full();
    int hit;
    in_item_t it;
    hit = $urandom_range(STACK_DEPTH - 1);
    send_item(make_item(CMD_FLUSH, 8'h00, 16'd0, 16'd0, 24'd0));
    for (int i = 0; i < STACK_DEPTH; i++) begin
      it = random_position(CMD_OPEN, pick_opener());
      if (i == hit)
        it.char_offset = cursor_shadow;
      else if (it.char_offset == cursor_shadow)
        it.char_offset = ~cursor_shadow;
      send_item(it);
    end
    it = random_position(CMD_OPEN, pick_opener());
    it.char_offset = cursor_shadow;
    send_item(it);
    send_item(random_position(CMD_OPEN, pick_opener()));
    send_item(random_position(CMD_FLUSH, 8'($urandom())));
  endtask

  // Random bracket stream: mostly well-formed nesting with random positions,
  // plus closes that skip or miss their opener, flushes and unused commands.
  task automatic test_random_stream(input int n_items);
    int       counted;
    int       pick;
    int       open_pct;
    logic [7:0] ch;
    counted = 0;
    while (counted < n_items) begin
      pick     = $urandom_range(99);
      // lean toward closing when the stack runs deep
      open_pct = (open_count > 24) ? 30 : 55;
      if (pick < 2) begin
        send_item(random_position(CMD_UNUSED, 8'($urandom())));
      end else begin
        if (pick < 5) begin
          send_item(random_position(CMD_FLUSH, 8'($urandom())));
        end else if (pick < open_pct) begin
          ch = ($urandom_range(9) == 0) ? 8'($urandom()) : pick_opener();
          send_item(random_position(CMD_OPEN, ch));
        end else begin
          pick = $urandom_range(99);
          if (open_count > 0 && pick < 75)
            ch = open_brackets[open_count - 1].ch;
          else if (open_count > 0 && pick < 88)
            ch = open_brackets[$urandom_range(open_count - 1)].ch;
          else
            ch = ($urandom_range(1) == 0) ? 8'($urandom()) : pick_opener();
          send_item(random_position(CMD_CLOSE, ch));
        end
        counted++;
      end
      // now and then let the block run dry before sending on
      if ($urandom_range(99) < 3)
        hold_until_drained();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_idle_pct   = 12;
    out_idle_pct  = 65;
    err_count     = 0;
    quiet_cycles  = 0;
    open_count    = 0;
    hilite_rec    = '0;
    cursor_shadow = '0;

    // hold reset, release it at a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase 1: sender idles rarely, receiver stalls often
    write_cursor(24'h000040);
    test_flush();
    test_matched_pairs();
    test_mismatched_close();
    test_unmatched_close();
    test_field_extremes();
    test_ignored_command();
    test_stack_full();
    test_random_stream(55);

    // phase 2: the other way round, cursor at its top value
    write_cursor(24'hFFFFFF);
    in_idle_pct  = 65;
    out_idle_pct = 12;
    test_random_stream(55);

    // phase 3: no idling on either side, cursor at zero then random
    write_cursor(24'h000000);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_stream(30);
    write_cursor(24'($urandom()));
    test_random_stream(20);

    // drain and let any trailing work settle
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
